// ===== hdl/rgbns_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbns_pkg
// Shared types and constants of the RGB565 nearest-neighbour scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbns_pkg;

  // Width of a source coordinate and of a source size register.
  localparam int SRC_W = 13;
  // Width of one target coordinate; covers target sizes up to 511.
  localparam int COORD_W = 9;
  // Widths of the framebuffer address and of the packed colour.
  localparam int ADDR_W = 14;
  localparam int COLOR_W = 16;
  // Configuration bus widths.
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  // Source sizes below this value are treated as this value.
  localparam logic [SRC_W-1:0] MIN_SOURCE = 13'd14;

  // A run of writes for one source pixel is cut after this many beats.
  localparam int MAX_RUN = 64;
  localparam int RUN_CNT_W = 6;

  // Number of jobs held between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic REG_SOURCE_WIDTH = 1'b0;
  localparam logic REG_SOURCE_HEIGHT = 1'b1;

  // One scaled pixel handed from the front to the back: the covered
  // target span, half open on the upper side, and the packed colour.
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [COLOR_W-1:0] color;
  } job_t;

  // Front state machine.
  typedef enum logic [1:0] {
    F_IDLE,
    F_DIVIDE,
    F_PUSH
  } front_state_t;

endpackage

`default_nettype wire

// ===== hdl/rgbns_front.sv =====
// ----------------------------------------------------------------------------
// rgbns_front
// Accepts source pixels, drops those outside the source image, and works out
// the covered target span with four restoring dividers running side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbns_front #(
  parameter int TARGET_SIZE = 112
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rgbns_pkg::SRC_W-1:0]   source_width,
  input  wire logic [rgbns_pkg::SRC_W-1:0]   source_height,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rgbns_pkg::SRC_W-1:0]   column,
  input  wire logic [rgbns_pkg::SRC_W-1:0]   row,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  output      logic                          job_valid,
  input  wire logic                          job_ready,
  output      rgbns_pkg::job_t               job
);

  // The quotient never exceeds TARGET_SIZE, so it needs TW bits.
  localparam int TW = $clog2(TARGET_SIZE + 1);
  localparam int QW = TW;
  localparam int DW = rgbns_pkg::SRC_W + 1 + TW;
  localparam int SW = rgbns_pkg::SRC_W + QW - 1;
  localparam int CW = $clog2(QW);
  localparam int LANES = 4;

  rgbns_pkg::front_state_t state, state_next;

  logic [rgbns_pkg::SRC_W-1:0]   w_eff;
  logic [rgbns_pkg::SRC_W-1:0]   h_eff;
  logic                          in_source;
  logic [DW-1:0]                 rem [LANES];
  logic [QW-1:0]                 quo [LANES];
  logic [QW-1:0]                 qc [LANES];
  logic [DW-1:0]                 dvs [LANES];
  logic                          ge [LANES];
  logic [SW-1:0]                 dsh_w;
  logic [SW-1:0]                 dsh_h;
  logic [CW-1:0]                 step_cnt;
  logic [rgbns_pkg::COLOR_W-1:0] color;
  logic                          span_ok;

  // Small sizes are raised to the minimum, which also keeps the divisor
  // away from zero.
  assign w_eff = (source_width < rgbns_pkg::MIN_SOURCE) ? rgbns_pkg::MIN_SOURCE
                                                         : source_width;
  assign h_eff = (source_height < rgbns_pkg::MIN_SOURCE) ? rgbns_pkg::MIN_SOURCE
                                                          : source_height;
  assign in_source = (column < w_eff) && (row < h_eff);

  // One trial subtraction per lane and cycle; lanes 0 and 1 divide by the
  // width, lanes 2 and 3 by the height.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dvs[l] = (l < 2) ? DW'(dsh_w) : DW'(dsh_h);
      ge[l]  = rem[l] >= dvs[l];
      qc[l]  = (quo[l] > QW'(TARGET_SIZE)) ? QW'(TARGET_SIZE) : quo[l];
    end
  end

  // A pixel whose span is empty in either direction causes no write.
  assign span_ok = (qc[0] < qc[1]) && (qc[2] < qc[3]);

  assign job.x0    = rgbns_pkg::COORD_W'(qc[0]);
  assign job.x1    = rgbns_pkg::COORD_W'(qc[1]);
  assign job.y0    = rgbns_pkg::COORD_W'(qc[2]);
  assign job.y1    = rgbns_pkg::COORD_W'(qc[3]);
  assign job.color = color;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbns_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    case (state)
      rgbns_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_source) begin
          state_next = rgbns_pkg::F_DIVIDE;
        end
      end
      rgbns_pkg::F_DIVIDE: begin
        if (step_cnt == '0) begin
          state_next = rgbns_pkg::F_PUSH;
        end
      end
      rgbns_pkg::F_PUSH: begin
        job_valid = span_ok;
        if (!span_ok || job_ready) begin
          state_next = rgbns_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = rgbns_pkg::F_IDLE;
      end
    endcase
  end

  // Dividend load while idle, then one quotient bit per cycle, most
  // significant first, with the divisor shifted down each step.
  always_ff @(posedge clk) begin
    if (state == rgbns_pkg::F_IDLE) begin
      rem[0]   <= DW'(column) * DW'(TARGET_SIZE);
      rem[1]   <= (DW'(column) + DW'(1)) * DW'(TARGET_SIZE);
      rem[2]   <= DW'(row) * DW'(TARGET_SIZE);
      rem[3]   <= (DW'(row) + DW'(1)) * DW'(TARGET_SIZE);
      dsh_w    <= {w_eff, {(QW-1){1'b0}}};
      dsh_h    <= {h_eff, {(QW-1){1'b0}}};
      step_cnt <= CW'(QW - 1);
      color    <= {red[7:3], green[7:2], blue[7:3]};
      for (int l = 0; l < LANES; l++) begin
        quo[l] <= '0;
      end
    end else if (state == rgbns_pkg::F_DIVIDE) begin
      for (int l = 0; l < LANES; l++) begin
        rem[l] <= ge[l] ? (rem[l] - dvs[l]) : rem[l];
        quo[l] <= {quo[l][QW-2:0], ge[l]};
      end
      dsh_w    <= dsh_w >> 1;
      dsh_h    <= dsh_h >> 1;
      step_cnt <= step_cnt - CW'(1);
    end
  end

  // The dividers must give ordered spans inside the target.
  a_span_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == rgbns_pkg::F_PUSH) |-> (qc[0] <= qc[1]) && (qc[2] <= qc[3]))
    else $error("front: target span out of order");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rgbns_pkg::F_PUSH) |->
      (quo[1] <= QW'(TARGET_SIZE)) && (quo[3] <= QW'(TARGET_SIZE)))
    else $error("front: quotient beyond target size");

endmodule

`default_nettype wire

// ===== hdl/rgbns_queue.sv =====
// ----------------------------------------------------------------------------
// rgbns_queue
// Short job queue between the front and the back so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbns_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output      logic            push_ready,
  input  wire rgbns_pkg::job_t push_job,
  output      logic            pop_valid,
  input  wire logic            pop_ready,
  output      rgbns_pkg::job_t pop_job
);

  localparam int DEPTH = rgbns_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  rgbns_pkg::job_t entry [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != NW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entry[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue: fill level beyond depth");

endmodule

`default_nettype wire

// ===== hdl/rgbns_back.sv =====
// ----------------------------------------------------------------------------
// rgbns_back
// Walks the target span of one job row by row and issues one framebuffer write
// beat per covered target pixel, up to MAX_RUN, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbns_back #(
  parameter int TARGET_SIZE = 112
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            job_valid,
  output      logic                            job_ready,
  input  wire rgbns_pkg::job_t                 job,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [rgbns_pkg::ADDR_W-1:0]    target_address,
  output      logic [rgbns_pkg::COLOR_W-1:0]   pixel_color,
  output      logic                            run_end
);

  localparam int CWD = rgbns_pkg::COORD_W;
  localparam int RBW = 2 * rgbns_pkg::COORD_W;

  logic                              active;
  logic [CWD-1:0]                    tx;
  logic [CWD-1:0]                    ty;
  logic [CWD-1:0]                    x0;
  logic [CWD-1:0]                    x1;
  logic [CWD-1:0]                    y1;
  logic [RBW-1:0]                    row_base;
  logic [rgbns_pkg::COLOR_W-1:0]     color;
  logic [rgbns_pkg::RUN_CNT_W-1:0]   beat_cnt;
  logic                              step;
  logic                              last_col;
  logic                              last_row;
  logic                              last;
  logic [RBW-1:0]                    addr_sum;

  assign job_ready = !active;
  assign step      = active && (!out_valid || out_ready);
  assign last_col  = (tx + CWD'(1)) == x1;
  assign last_row  = (ty + CWD'(1)) == y1;
  assign last      = (last_col && last_row) ||
                     (beat_cnt == rgbns_pkg::RUN_CNT_W'(rgbns_pkg::MAX_RUN - 1));
  assign addr_sum  = row_base + RBW'(tx);

  // Run control and output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!active && job_valid) begin
        active <= 1'b1;
      end else if (step && last) begin
        active <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Span walk: columns inside a row, then the next row with its base
  // address moved on by one target row.
  always_ff @(posedge clk) begin
    if (!active) begin
      tx       <= job.x0;
      x0       <= job.x0;
      x1       <= job.x1;
      ty       <= job.y0;
      y1       <= job.y1;
      color    <= job.color;
      row_base <= RBW'(job.y0) * RBW'(TARGET_SIZE);
      beat_cnt <= '0;
    end else if (step) begin
      beat_cnt <= beat_cnt + rgbns_pkg::RUN_CNT_W'(1);
      if (last_col) begin
        tx       <= x0;
        ty       <= ty + CWD'(1);
        row_base <= row_base + RBW'(TARGET_SIZE);
      end else begin
        tx <= tx + CWD'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (step) begin
      target_address <= addr_sum[rgbns_pkg::ADDR_W-1:0];
      pixel_color    <= color;
      run_end        <= last;
    end
  end

  a_walk_in_span: assert property (@(posedge clk) disable iff (rst)
    active |-> (tx >= x0) && (tx < x1) && (ty < y1))
    else $error("back: walk left the target span");

  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> !active && out_valid && run_end)
    else $error("back: run did not close on its last beat");

  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    (active && !(step && last)) |=> active && $stable(x1) && $stable(y1))
    else $error("back: span changed in the middle of a run");

endmodule

`default_nettype wire

// ===== hdl/rgb565_nearest_scaler_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_nearest_scaler_core
// Nearest-neighbour scaler from RGB888 source pixels to RGB565 writes into a
// square framebuffer of TARGET_SIZE pixels per side.
// ----------------------------------------------------------------------------
// Each accepted source pixel is checked against the source size (values
// below 14 count as 14) and mapped to the target span column*T/width up to
// (column+1)*T/width, rows alike; the block then issues one write beat per
// covered target pixel, row by row, with run_end on the last one, and none
// for a pixel outside the source or with an empty span. The front works out
// each pixel's span with four restoring dividers that produce one quotient
// bit a cycle; the back issues one write beat per cycle while out_ready does
// not hold it, and loads each run while idle, so when upscaling the rate
// follows the run length, at most 64 beats. A two-entry job queue lets the
// front work on the next pixel while the back is busy.
// The source sizes sit on an APB-style port at byte addresses 0 and 4 and
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_nearest_scaler_core #(
  parameter int TARGET_SIZE = 112
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rgbns_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rgbns_pkg::DATA_W-1:0]    pwdata,
  output      logic [rgbns_pkg::DATA_W-1:0]    prdata,
  output      logic                            pready,
  // Source pixels.
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [rgbns_pkg::SRC_W-1:0]     column,
  input  wire logic [rgbns_pkg::SRC_W-1:0]     row,
  input  wire logic [7:0]                      red,
  input  wire logic [7:0]                      green,
  input  wire logic [7:0]                      blue,
  // Framebuffer writes.
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [rgbns_pkg::ADDR_W-1:0]    target_address,
  output      logic [rgbns_pkg::COLOR_W-1:0]   pixel_color,
  output      logic                            run_end
);

  logic [rgbns_pkg::SRC_W-1:0] source_width;
  logic [rgbns_pkg::SRC_W-1:0] source_height;
  logic                        cfg_write;
  logic                        reg_index;

  logic            fq_valid;
  logic            fq_ready;
  rgbns_pkg::job_t fq_job;
  logic            qb_valid;
  logic            qb_ready;
  rgbns_pkg::job_t qb_job;

  // Register decode: the index is the word address.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 13'd112;
      source_height <= 13'd112;
    end else if (cfg_write) begin
      case (reg_index)
        rgbns_pkg::REG_SOURCE_WIDTH: begin
          source_width <= pwdata[rgbns_pkg::SRC_W-1:0];
        end
        rgbns_pkg::REG_SOURCE_HEIGHT: begin
          source_height <= pwdata[rgbns_pkg::SRC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_index)
      rgbns_pkg::REG_SOURCE_WIDTH:  prdata = rgbns_pkg::DATA_W'(source_width);
      rgbns_pkg::REG_SOURCE_HEIGHT: prdata = rgbns_pkg::DATA_W'(source_height);
      default:                      prdata = '0;
    endcase
  end

  // Front: classification and span division.
  rgbns_front #(
    .TARGET_SIZE(TARGET_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .source_width  (source_width),
    .source_height (source_height),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .column        (column),
    .row           (row),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job           (fq_job)
  );

  // Job queue.
  rgbns_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  // Back: write beat generation.
  rgbns_back #(
    .TARGET_SIZE(TARGET_SIZE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (qb_valid),
    .job_ready      (qb_ready),
    .job            (qb_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .target_address (target_address),
    .pixel_color    (pixel_color),
    .run_end        (run_end)
  );

endmodule

`default_nettype wire
